// File: rtl/core/pdc_pkg.sv
// Shared types, widths and codes for the PID position/delta controller.
package pdc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GAIN_W       = 16;
  localparam int DRIVE_W      = 32;
  localparam int LIM_W        = DRIVE_W - 1;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;

  // error, first difference and second difference widths
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int D1_W   = SAMPLE_WIDTH + 2;
  localparam int D2_W   = SAMPLE_WIDTH + 3;
  localparam int PROD_W = GAIN_W + D2_W;
  localparam int ACC_W  = ((PROD_W > DRIVE_W) ? PROD_W : DRIVE_W) + 2;

  typedef logic [1:0]                     cmd_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [DRIVE_W-1:0]      drive_t;

  localparam cmd_t CMD_CALC  = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_START = 2'd2;

  localparam logic [2:0] REG_LOOP_MODE   = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd3;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;

endpackage

// File: rtl/core/pdc_if.sv
// Valid/ready channels for the controller's sample input and drive output.
interface pdc_sample_if;
  logic             valid;
  logic             ready;
  pdc_pkg::cmd_t    cmd;
  pdc_pkg::sample_t target;
  pdc_pkg::sample_t measured;

  modport source (output valid, output cmd, output target, output measured, input ready);
  modport sink   (input valid, input cmd, input target, input measured, output ready);
endinterface

interface pdc_result_if;
  logic            valid;
  logic            ready;
  pdc_pkg::drive_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// File: rtl/core/pid_position_delta_controller_top.sv
// PID controller top level: APB register file, input register, PID update, result register.
// One beat is accepted per clock while result.ready holds, and one drive beat leaves per accepted
// beat, so the block sustains one item per cycle unless the result side stalls. The input register
// takes a beat when it is accepted, and the single PID update pass writes the result register when
// that register is free or being emptied; the result is then held there until it is taken.
// That pass holds the three gain multipliers and the add/clamp chain,
// and it sets the clock rate. Registers sit at byte address 4*i: loop_mode, prop_gain,
// integ_gain, deriv_gain, out_limit, integ_limit; write them only while the block is idle.
module pid_position_delta_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pdc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  pdc_sample_if.sink                         sample,
  pdc_result_if.source                       result
);
  import pdc_pkg::*;

  // configuration registers
  logic                     loop_mode;
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic [LIM_W-1:0]         out_limit;
  logic [LIM_W-1:0]         integ_limit;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode   <= 1'b0;
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      out_limit   <= '0;
      integ_limit <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOOP_MODE:   loop_mode   <= pwdata[0];
        REG_PROP_GAIN:   prop_gain   <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= pwdata[GAIN_W-1:0];
        REG_OUT_LIMIT:   out_limit   <= pwdata[LIM_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOOP_MODE:   prdata = {{(CFG_DATA_W-1){1'b0}}, loop_mode};
      REG_PROP_GAIN:   prdata = CFG_DATA_W'(prop_gain);
      REG_INTEG_GAIN:  prdata = CFG_DATA_W'(integ_gain);
      REG_DERIV_GAIN:  prdata = CFG_DATA_W'(deriv_gain);
      REG_OUT_LIMIT:   prdata = {1'b0, out_limit};
      REG_INTEG_LIMIT: prdata = {1'b0, integ_limit};
      default:         prdata = '0;
    endcase
  end

  // clamp to +-lim
  function automatic drive_t clamp_sym(input logic signed [ACC_W-1:0] v,
                                       input logic [LIM_W-1:0] lim);
    logic signed [ACC_W-1:0] limx;
    limx = signed'(ACC_W'(lim));
    if (v > limx)
      return DRIVE_W'(limx);
    else if (v < -limx)
      return DRIVE_W'(-limx);
    else
      return DRIVE_W'(v);
  endfunction

  // saturate to the drive word
  function automatic drive_t sat_drive(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = signed'(ACC_W'({1'b0, {(DRIVE_W-1){1'b1}}}));
    lo = ~hi;
    if (v > hi)
      return DRIVE_W'(hi);
    else if (v < lo)
      return DRIVE_W'(lo);
    else
      return DRIVE_W'(v);
  endfunction

  // input register
  logic    s1_valid;
  cmd_t    s1_cmd;
  sample_t s1_target;
  sample_t s1_measured;
  logic    res_valid;
  logic    adv;

  assign adv          = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_cmd      <= sample.cmd;
      s1_target   <= sample.target;
      s1_measured <= sample.measured;
    end
  end

  // controller state; out_acc doubles as the result register
  logic                    running;
  logic signed [ERR_W-1:0] err_prev;
  logic signed [ERR_W-1:0] err_prev2;
  drive_t                  integ_acc;
  drive_t                  out_acc;

  logic                    running_next;
  logic signed [ERR_W-1:0] err_prev_next;
  logic signed [ERR_W-1:0] err_prev2_next;
  drive_t                  integ_acc_next;
  drive_t                  out_acc_next;

  logic signed [ERR_W-1:0]        err;
  logic signed [D1_W-1:0]         d1;
  logic signed [D2_W-1:0]         d2;
  logic signed [D2_W-1:0]         kp_opd;
  logic signed [D2_W-1:0]         kd_opd;
  logic signed [GAIN_W+D2_W-1:0]  kp_term;
  logic signed [GAIN_W+ERR_W-1:0] ki_term;
  logic signed [GAIN_W+D2_W-1:0]  kd_term;
  logic signed [ACC_W-1:0]        integ_sum;
  drive_t                         integ_pos;
  logic signed [ACC_W-1:0]        pos_sum;
  logic signed [ACC_W-1:0]        inc_sum;

  always_comb begin
    err = ERR_W'(s1_target) - ERR_W'(s1_measured);
    d1  = D1_W'(err) - D1_W'(err_prev);
    d2  = D2_W'(err) - (D2_W'(err_prev) <<< 1) + D2_W'(err_prev2);

    // positional uses e and (e - e1); incremental uses (e - e1) and the second difference
    kp_opd = loop_mode ? D2_W'(d1) : D2_W'(err);
    kd_opd = loop_mode ? d2 : D2_W'(d1);

    kp_term = prop_gain * kp_opd;
    ki_term = integ_gain * err;
    kd_term = deriv_gain * kd_opd;

    integ_sum = ACC_W'(integ_acc) + ACC_W'(ki_term);
    integ_pos = clamp_sym(integ_sum, integ_limit);
    pos_sum   = ACC_W'(kp_term) + ACC_W'(integ_pos) + ACC_W'(kd_term);
    inc_sum   = ACC_W'(out_acc) + ACC_W'(kp_term) + ACC_W'(ki_term) + ACC_W'(kd_term);

    running_next   = running;
    err_prev_next  = err_prev;
    err_prev2_next = err_prev2;
    integ_acc_next = integ_acc;
    out_acc_next   = out_acc;

    unique case (s1_cmd)
      CMD_CALC: begin
        if (!running) begin
          err_prev_next  = '0;
          err_prev2_next = '0;
          integ_acc_next = '0;
          out_acc_next   = '0;
        end else begin
          err_prev_next  = err;
          err_prev2_next = err_prev;
          if (!loop_mode) begin
            integ_acc_next = integ_pos;
            out_acc_next   = clamp_sym(pos_sum, out_limit);
          end else begin
            integ_acc_next = sat_drive(ACC_W'(ki_term));
            out_acc_next   = clamp_sym(inc_sum, out_limit);
          end
        end
      end
      CMD_CLEAR: begin
        running_next   = 1'b0;
        err_prev_next  = '0;
        err_prev2_next = '0;
        integ_acc_next = '0;
        out_acc_next   = '0;
      end
      CMD_START: begin
        if (!running) begin
          running_next   = 1'b1;
          err_prev_next  = '0;
          err_prev2_next = '0;
          integ_acc_next = '0;
          out_acc_next   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      err_prev  <= '0;
      err_prev2 <= '0;
      integ_acc <= '0;
      out_acc   <= '0;
    end else if (adv) begin
      running   <= running_next;
      err_prev  <= err_prev_next;
      err_prev2 <= err_prev2_next;
      integ_acc <= integ_acc_next;
      out_acc   <= out_acc_next;
    end
  end

  // result beat; out_acc only moves when the result stage is free or its beat is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid = res_valid;
  assign result.drive = out_acc;

`ifndef SYNTHESIS
  a_stopped_state_zero: assert property (@(posedge clk) disable iff (rst)
    !running |-> (out_acc == '0) && (integ_acc == '0) && (err_prev == '0)
                 && (err_prev2 == '0))
    else $error("state not zero while stopped");

  a_clear_stops: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_cmd == CMD_CLEAR) |=> !running && (result.drive == '0))
    else $error("clear did not stop the loop");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_cmd == CMD_START) |=> running)
    else $error("start did not set running");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> sample.ready)
    else $error("input stalled with the result stage empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid)
    else $error("processed beat gave no result");
`endif

endmodule
